// ===== sv/ffd_pkg.sv =====
package ffd_pkg;

  localparam int unsigned WIN_LEN = 16;
  localparam int unsigned FILL_W = $clog2(WIN_LEN + 1);

  localparam logic [7:0] SYNC_HEAD = 8'hAA;
  localparam logic [7:0] SYNC_TAIL = 8'h55;
  localparam logic [7:0] STATUS_CMD = 8'h11;
  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  // Index 0 is the oldest byte of the window (frame byte 0).
  typedef logic [WIN_LEN-1:0][7:0] win_t;

  typedef struct packed {
    logic [11:0] torque_raw;
    logic [11:0] vel_raw;
    logic [15:0] pos_raw;
    logic [15:0] reply_id;
    logic        by_master_id;
    logic        is_status;
    logic [63:0] payload;
    logic [31:0] bus_id;
    logic [7:0]  frame_cmd;
  } result_t;

  // Handshake between the window and the output stage.
  typedef struct packed {
    logic hit;
    logic move;
  } frame_ctl_t;

endpackage

// ===== sv/ffd_window.sv =====
module ffd_window (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  input  logic              move,
  output ffd_pkg::win_t     win_r,
  output ffd_pkg::frame_ctl_t ctl
);

  localparam logic [ffd_pkg::FILL_W-1:0] FULL_CNT = ffd_pkg::FILL_W'(ffd_pkg::WIN_LEN);
  localparam logic [ffd_pkg::FILL_W-1:0] LAST_CNT = ffd_pkg::FILL_W'(ffd_pkg::WIN_LEN - 1);

  logic [ffd_pkg::FILL_W-1:0] fill_r;
  logic [ffd_pkg::FILL_W-1:0] fill_nxt;
  ffd_pkg::win_t              win_nxt;
  logic                       hit_r;
  logic                       hit_nxt;
  logic                       match;

  // The window shifts on every accepted byte: once 16 bytes have arrived
  // since the last frame, it holds exactly those bytes in arrival order.
  assign win_nxt = {rx_byte, win_r[ffd_pkg::WIN_LEN-1:1]};

  // The frame check looks at the window as it will be after this byte.
  assign match = (fill_r >= LAST_CNT) && (win_r[1] == ffd_pkg::SYNC_HEAD) &&
                 (rx_byte == ffd_pkg::SYNC_TAIL);

  always_comb begin
    fill_nxt = fill_r;
    hit_nxt  = hit_r && !move;
    if (accept) begin
      if (match) begin
        fill_nxt = '0;
        hit_nxt  = 1'b1;
      end else if (fill_r < FULL_CNT) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      hit_r  <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      hit_r  <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

  assign ctl.hit  = hit_r;
  assign ctl.move = move;

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT)
    else $error("fill count beyond window length");

  a_match_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && match |=> (fill_r == '0) && hit_r)
    else $error("matched frame did not empty the window");

  a_hit_held: assert property (@(posedge clk) disable iff (!rst_n)
    hit_r && !move && !accept |=> hit_r)
    else $error("pending frame dropped before hand-off");

endmodule

// ===== sv/ffd_decode.sv =====
module ffd_decode (
  input  ffd_pkg::win_t    win,
  output ffd_pkg::result_t res
);

  logic [31:0] id;
  logic [63:0] pl;
  logic        status;
  logic        id_zero;

  assign id = {win[6], win[5], win[4], win[3]};
  assign pl = {win[7], win[8], win[9], win[10], win[11], win[12], win[13], win[14]};
  assign status  = (win[1] == ffd_pkg::STATUS_CMD);
  assign id_zero = (id == 32'd0);

  always_comb begin
    res              = '0;
    res.frame_cmd    = win[1];
    res.bus_id       = id;
    res.payload      = pl;
    if (status) begin
      res.is_status    = 1'b1;
      res.by_master_id = id_zero;
      res.reply_id     = id_zero ? {12'd0, win[7][3:0] & ffd_pkg::NIBBLE_MASK} : id[15:0];
      res.pos_raw      = {win[8], win[9]};
      res.vel_raw      = {win[10], win[11][7:4]};
      res.torque_raw   = {win[11][3:0], win[12]};
    end
  end

endmodule

// ===== sv/ffd_out_reg.sv =====
module ffd_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  ffd_pkg::result_t res,
  input  logic             ready,
  output logic             can_load,
  output logic             valid_r,
  output ffd_pkg::result_t res_r
);

  logic valid_nxt;

  assign can_load  = !valid_r || ready;
  assign valid_nxt = load || (valid_r && !ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

// ===== sv/fixed_frame_deframer_feedback_decode_core.sv =====
// Channel  Direction  tdata / tuser contents
// in_      slave      tdata[7:0] rx_byte
// out_     master     tdata: frame_cmd, bus_id, payload, reply_id, pos_raw, vel_raw,
//                     torque_raw; tuser: is_status, by_master_id
//
// One byte is taken every cycle while in_tready is high. The edge that takes a frame's
// last byte sets the pending flag; out_tvalid rises once the output register loads it.
// The shift window and one output register set the rate; decode sits between them.
// Reset empties the window and drops any pending frame; no clearing pass is needed.
// While a decoded frame waits in the output register and another frame is pending
// in the window, in_tready is low until out_tready frees the register.
module fixed_frame_deframer_feedback_decode_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] rx_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // [7:0] frame_cmd, [39:8] bus_id, [103:40] payload,
                                   // [119:104] reply_id, [135:120] pos_raw,
                                   // [147:136] vel_raw, [159:148] torque_raw
  output logic [1:0]   out_tuser   // [0] is_status, [1] by_master_id
);

  ffd_pkg::win_t       win;
  ffd_pkg::frame_ctl_t ctl;
  ffd_pkg::result_t    res;
  ffd_pkg::result_t    res_r;
  logic                accept;
  logic                can_load;
  logic                move;

  // A pending frame must leave the window before the next byte shifts it.
  assign move      = ctl.hit && can_load;
  assign in_tready = !ctl.hit || can_load;
  assign accept    = in_tvalid && in_tready;

  ffd_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_tdata),
    .move    (move),
    .win_r   (win),
    .ctl     (ctl)
  );

  ffd_decode u_decode (
    .win (win),
    .res (res)
  );

  ffd_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (ctl.move),
    .res      (res),
    .ready    (out_tready),
    .can_load (can_load),
    .valid_r  (out_tvalid),
    .res_r    (res_r)
  );

  assign out_tdata = {res_r.torque_raw, res_r.vel_raw, res_r.pos_raw, res_r.reply_id,
                      res_r.payload, res_r.bus_id, res_r.frame_cmd};
  assign out_tuser = {res_r.by_master_id, res_r.is_status};

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> ctl.hit && out_tvalid && !out_tready)
    else $error("input stalled without a blocked frame");

  a_move_fills: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> out_tvalid)
    else $error("frame hand-off did not fill the output register");

  a_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> !out_tuser[1] && (out_tdata[159:104] == '0))
    else $error("non-status frame carries status fields");

endmodule
